>>> hw/rtl/pgvu_pkg.sv
// ----------------------------------------------------------------------------
// pgvu_pkg - shared types and helpers for the pairwise gravity velocity update
// word width, pipeline step counts, the sideband record and the word clamp
// ----------------------------------------------------------------------------
package pgvu_pkg;

    localparam int W          = 32;
    localparam int SQ_STEPS   = W;        // one root bit per stage
    localparam int DIV_STEPS  = 2 * W;    // one quotient bit per stage

    localparam logic [W-1:0] G_RESET = 32'h0001_0000;   // 1.0 in q16.16

    localparam logic signed [34:0] WMAX35 = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] WMIN35 = 35'sh7_8000_0000;

    // values that ride alongside the arithmetic through every stage before the output
    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               negx;
        logic               negy;
        logic               coinc;
        logic               sat;
        logic [95:0]        num;
        logic [31:0]        r;
    } side_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } clamp_t;

    // clamp a wide signed value to the signed word range
    function automatic clamp_t clamp_w(input logic signed [34:0] v);
        clamp_t c;
        if (v > WMAX35)
        begin
            c.sat = 1'b1;
            c.val = WMAX35[31:0];
        end
        else if (v < WMIN35)
        begin
            c.sat = 1'b1;
            c.val = WMIN35[31:0];
        end
        else
        begin
            c.sat = 1'b0;
            c.val = v[31:0];
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/pairwise_gravity_velocity_update_top.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_velocity_update_top - gravity velocity update for a body pair
// streams body pairs in q16.16 and returns both velocities after attraction
// ----------------------------------------------------------------------------
// The block accepts one body pair per clock and returns one beat per pair,
// in order. Its path is a chain of one-bit stages: 32 square root stages
// for the distance and 64 restoring divider stages for k = m1*m2*G / r^3,
// plus ten stages of offset, multiply and saturating add around them. All
// stages move together; a stalled output beat freezes the whole pipe, so
// nothing is lost or repeated, and the input is stalled only while the output
// beat waits. G is written through the configuration channel (always ready)
// and must only change while the pipe holds no pair. Coincident bodies pass
// their velocities through unchanged with coincident set and saturated
// clear; for any other pair, a clamp on the way sets saturated.
module pairwise_gravity_velocity_update_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic [31:0] first_mass,
    input  logic [31:0] second_mass,
    input  logic signed [31:0] first_vel_x,
    input  logic signed [31:0] first_vel_y,
    input  logic signed [31:0] second_vel_x,
    input  logic signed [31:0] second_vel_y,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] new_first_vel_x,
    output logic signed [31:0] new_first_vel_y,
    output logic signed [31:0] new_second_vel_x,
    output logic signed [31:0] new_second_vel_y,
    output logic        coincident,
    output logic        saturated
);
    import pgvu_pkg::*;

    // gravity constant register
    logic [31:0] g_reg;

    // whole-pipe advance
    logic adv;

    // front stages
    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg;
    side_t       s1_side_reg, s1_side_next;
    logic signed [31:0] s1_dx_reg, s1_dy_reg;
    logic [31:0] s1_m1_reg, s1_m2_reg;
    side_t       s2_side_reg, s2_side_next;
    logic [63:0] s2_sqx_reg, s2_sqy_reg, s2_mp_reg;
    side_t       s3_side_reg;
    logic [63:0] s3_r2_reg, s3_nlo_reg, s3_nhi_reg;

    // square root stages
    logic         sq_vld_reg  [SQ_STEPS];
    side_t        sq_side_reg [SQ_STEPS];
    side_t        sq_side_next[SQ_STEPS];
    logic [63:0]  sq_src_reg  [SQ_STEPS];
    logic [63:0]  sq_src_next [SQ_STEPS];
    logic [34:0]  sq_rem_reg  [SQ_STEPS];
    logic [34:0]  sq_rem_next [SQ_STEPS];
    logic [31:0]  sq_root_reg [SQ_STEPS];
    logic [31:0]  sq_root_next[SQ_STEPS];

    // r^3 stages
    logic         rr_vld_reg, rp_vld_reg, r3_vld_reg, di_vld_reg;
    side_t        rr_side_reg, rr_side_next;
    logic [63:0]  rr_reg;
    side_t        rp_side_reg;
    logic [63:0]  rp_lo_reg, rp_hi_reg;
    side_t        r3_side_reg;
    logic [95:0]  r3_reg;

    // divider set-up and stages
    side_t        di_side_reg;
    logic         di_ovf_reg;
    logic [95:0]  di_r3_reg;
    logic [96:0]  di_rem_reg;
    logic [63:0]  di_src_reg;

    logic         dv_vld_reg  [DIV_STEPS];
    side_t        dv_side_reg [DIV_STEPS];
    logic         dv_ovf_reg  [DIV_STEPS];
    logic [95:0]  dv_r3_reg   [DIV_STEPS];
    logic [96:0]  dv_rem_reg  [DIV_STEPS];
    logic [96:0]  dv_rem_next [DIV_STEPS];
    logic [63:0]  dv_src_reg  [DIV_STEPS];
    logic [63:0]  dv_q_reg    [DIV_STEPS];
    logic [63:0]  dv_q_next   [DIV_STEPS];

    // delta and output stages
    logic         mu_vld_reg, dl_vld_reg, out_valid_reg;
    side_t        mu_side_reg, mu_side_next;
    logic [63:0]  mu_xl_reg, mu_xh_reg, mu_yl_reg, mu_yh_reg;
    logic [63:0]  mu_k;
    side_t        dl_side_reg, dl_side_next;
    logic [32:0]  dl_mx_reg, dl_my_reg, dl_mx_next, dl_my_next;
    logic [95:0]  dl_px, dl_py;

    logic signed [31:0] o_v1x_reg, o_v1y_reg, o_v2x_reg, o_v2y_reg;
    logic signed [31:0] o_v1x_next, o_v1y_next, o_v2x_next, o_v2y_next;
    logic         o_coinc_reg, o_sat_reg, o_coinc_next, o_sat_next;

    assign cfg_ready = 1'b1;
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_reg <= G_RESET;
        else if (cfg_valid && cfg_ready)
            g_reg <= cfg_data;
    end

    // ---------------- stage 1: offsets, clamped to the word ----------------
    always_comb
    begin
        clamp_t cx;
        clamp_t cy;
        cx = clamp_w(35'(second_pos_x) - 35'(first_pos_x));
        cy = clamp_w(35'(second_pos_y) - 35'(first_pos_y));
        s1_side_next       = '0;
        s1_side_next.v1x   = first_vel_x;
        s1_side_next.v1y   = first_vel_y;
        s1_side_next.v2x   = second_vel_x;
        s1_side_next.v2y   = second_vel_y;
        s1_side_next.sat   = cx.sat | cy.sat;
        s1_side_next.ax    = cx.val;     // holds dx until stage 2
        s1_side_next.ay    = cy.val;
    end

    // ---------------- stage 2: magnitudes squared, mass product ----------------
    logic [31:0] s2_ax, s2_ay;
    always_comb
    begin
        s2_ax             = s1_dx_reg[31] ? 32'(-s1_dx_reg) : s1_dx_reg;
        s2_ay             = s1_dy_reg[31] ? 32'(-s1_dy_reg) : s1_dy_reg;
        s2_side_next      = s1_side_reg;
        s2_side_next.ax   = s2_ax;
        s2_side_next.ay   = s2_ay;
        s2_side_next.negx = s1_dx_reg[31];
        s2_side_next.negy = s1_dy_reg[31];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg <= s1_side_next;
            s1_dx_reg   <= s1_side_next.ax;
            s1_dy_reg   <= s1_side_next.ay;
            s1_m1_reg   <= first_mass;
            s1_m2_reg   <= second_mass;

            s2_side_reg <= s2_side_next;
            s2_sqx_reg  <= 64'(s2_ax) * 64'(s2_ax);
            s2_sqy_reg  <= 64'(s2_ay) * 64'(s2_ay);
            s2_mp_reg   <= 64'(s1_m1_reg) * 64'(s1_m2_reg);

            // stage 3: distance squared, partial products of m1*m2*G
            s3_side_reg <= s2_side_reg;
            s3_r2_reg   <= s2_sqx_reg + s2_sqy_reg;
            s3_nlo_reg  <= 64'(s2_mp_reg[31:0]) * 64'(g_reg);
            s3_nhi_reg  <= 64'(s2_mp_reg[63:32]) * 64'(g_reg);
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    always_comb
    begin
        logic [63:0] src;
        logic [34:0] rem;
        logic [31:0] root;
        logic [34:0] rs;
        logic [34:0] trial;
        side_t       sd;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            if (i == 0)
            begin
                src      = s3_r2_reg;
                rem      = '0;
                root     = '0;
                sd       = s3_side_reg;
                sd.num   = {32'b0, s3_nlo_reg} + {s3_nhi_reg, 32'b0};
                sd.coinc = (s3_r2_reg == 64'd0);
            end
            else
            begin
                src  = sq_src_reg[i-1];
                rem  = sq_rem_reg[i-1];
                root = sq_root_reg[i-1];
                sd   = sq_side_reg[i-1];
            end
            rs    = {rem[32:0], src[63:62]};
            trial = {1'b0, root, 2'b01};
            if (rs >= trial)
            begin
                sq_rem_next[i]  = rs - trial;
                sq_root_next[i] = {root[30:0], 1'b1};
            end
            else
            begin
                sq_rem_next[i]  = rs;
                sq_root_next[i] = {root[30:0], 1'b0};
            end
            sq_src_next[i]  = {src[61:0], 2'b00};
            sq_side_next[i] = sd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                sq_side_reg[i] <= sq_side_next[i];
                sq_src_reg[i]  <= sq_src_next[i];
                sq_rem_reg[i]  <= sq_rem_next[i];
                sq_root_reg[i] <= sq_root_next[i];
            end
        end
    end

    // ---------------- r^3 in three stages ----------------
    always_comb
    begin
        rr_side_next   = sq_side_reg[SQ_STEPS-1];
        rr_side_next.r = sq_root_reg[SQ_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rr_side_reg <= rr_side_next;
            rr_reg      <= 64'(rr_side_next.r) * 64'(rr_side_next.r);

            rp_side_reg <= rr_side_reg;
            rp_lo_reg   <= 64'(rr_reg[31:0]) * 64'(rr_side_reg.r);
            rp_hi_reg   <= 64'(rr_reg[63:32]) * 64'(rr_side_reg.r);

            r3_side_reg <= rp_side_reg;
            r3_reg      <= {32'b0, rp_lo_reg} + {rp_hi_reg, 32'b0};

            // divider set-up: quotient overflow when num >= r3 * 2^32
            di_side_reg <= r3_side_reg;
            di_ovf_reg  <= ({32'b0, r3_side_reg.num} >= {r3_reg, 32'b0});
            di_r3_reg   <= r3_reg;
            di_rem_reg  <= {33'b0, r3_side_reg.num[95:32]};
            di_src_reg  <= {r3_side_reg.num[31:0], 32'b0};
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    always_comb
    begin
        logic [96:0] rem;
        logic [96:0] rs;
        logic [95:0] dvs;
        logic [63:0] src;
        logic [63:0] q;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                rem = di_rem_reg;
                dvs = di_r3_reg;
                src = di_src_reg;
                q   = '0;
            end
            else
            begin
                rem = dv_rem_reg[i-1];
                dvs = dv_r3_reg[i-1];
                src = dv_src_reg[i-1];
                q   = dv_q_reg[i-1];
            end
            rs = {rem[95:0], src[63]};
            if (rs >= {1'b0, dvs})
            begin
                dv_rem_next[i] = rs - {1'b0, dvs};
                dv_q_next[i]   = {q[62:0], 1'b1};
            end
            else
            begin
                dv_rem_next[i] = rs;
                dv_q_next[i]   = {q[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                dv_rem_reg[i] <= dv_rem_next[i];
                dv_q_reg[i]   <= dv_q_next[i];
                if (i == 0)
                begin
                    dv_side_reg[i] <= di_side_reg;
                    dv_ovf_reg[i]  <= di_ovf_reg;
                    dv_r3_reg[i]   <= di_r3_reg;
                    dv_src_reg[i]  <= {di_src_reg[62:0], 1'b0};
                end
                else
                begin
                    dv_side_reg[i] <= dv_side_reg[i-1];
                    dv_ovf_reg[i]  <= dv_ovf_reg[i-1];
                    dv_r3_reg[i]   <= dv_r3_reg[i-1];
                    dv_src_reg[i]  <= {dv_src_reg[i-1][62:0], 1'b0};
                end
            end
        end
    end

    // ---------------- k * |d| as 32-bit partial products ----------------
    always_comb
    begin
        mu_k             = dv_ovf_reg[DIV_STEPS-1] ? '1 : dv_q_reg[DIV_STEPS-1];
        mu_side_next     = dv_side_reg[DIV_STEPS-1];
        mu_side_next.sat = dv_side_reg[DIV_STEPS-1].sat | dv_ovf_reg[DIV_STEPS-1];
    end

    // delta magnitude, clamped to 2^32
    always_comb
    begin
        dl_px        = {32'b0, mu_xl_reg} + {mu_xh_reg, 32'b0};
        dl_py        = {32'b0, mu_yl_reg} + {mu_yh_reg, 32'b0};
        dl_side_next = mu_side_reg;
        if (dl_px[95:32] > 64'h1_0000_0000)
        begin
            dl_mx_next       = 33'h1_0000_0000;
            dl_side_next.sat = 1'b1;
        end
        else
            dl_mx_next = dl_px[64:32];
        if (dl_py[95:32] > 64'h1_0000_0000)
        begin
            dl_my_next       = 33'h1_0000_0000;
            dl_side_next.sat = 1'b1;
        end
        else
            dl_my_next = dl_py[64:32];
    end

    // saturating velocity sums, coincident bypass
    always_comb
    begin
        logic signed [34:0] sdx;
        logic signed [34:0] sdy;
        clamp_t c1x;
        clamp_t c1y;
        clamp_t c2x;
        clamp_t c2y;
        sdx = dl_side_reg.negx ? -$signed({2'b0, dl_mx_reg}) : $signed({2'b0, dl_mx_reg});
        sdy = dl_side_reg.negy ? -$signed({2'b0, dl_my_reg}) : $signed({2'b0, dl_my_reg});
        c1x = clamp_w(35'(dl_side_reg.v1x) + sdx);
        c1y = clamp_w(35'(dl_side_reg.v1y) + sdy);
        c2x = clamp_w(35'(dl_side_reg.v2x) - sdx);
        c2y = clamp_w(35'(dl_side_reg.v2y) - sdy);
        o_coinc_next = dl_side_reg.coinc;
        if (dl_side_reg.coinc)
        begin
            o_v1x_next = dl_side_reg.v1x;
            o_v1y_next = dl_side_reg.v1y;
            o_v2x_next = dl_side_reg.v2x;
            o_v2y_next = dl_side_reg.v2y;
            o_sat_next = 1'b0;
        end
        else
        begin
            o_v1x_next = c1x.val;
            o_v1y_next = c1y.val;
            o_v2x_next = c2x.val;
            o_v2y_next = c2y.val;
            o_sat_next = dl_side_reg.sat | c1x.sat | c1y.sat | c2x.sat | c2y.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mu_side_reg <= mu_side_next;
            mu_xl_reg   <= 64'(mu_k[31:0])  * 64'(mu_side_next.ax);
            mu_xh_reg   <= 64'(mu_k[63:32]) * 64'(mu_side_next.ax);
            mu_yl_reg   <= 64'(mu_k[31:0])  * 64'(mu_side_next.ay);
            mu_yh_reg   <= 64'(mu_k[63:32]) * 64'(mu_side_next.ay);

            dl_side_reg <= dl_side_next;
            dl_mx_reg   <= dl_mx_next;
            dl_my_reg   <= dl_my_next;

            o_v1x_reg   <= o_v1x_next;
            o_v1y_reg   <= o_v1y_next;
            o_v2x_reg   <= o_v2x_next;
            o_v2y_reg   <= o_v2y_next;
            o_coinc_reg <= o_coinc_next;
            o_sat_reg   <= o_sat_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            for (int i = 0; i < SQ_STEPS; i++)
                sq_vld_reg[i] <= 1'b0;
            rr_vld_reg    <= 1'b0;
            rp_vld_reg    <= 1'b0;
            r3_vld_reg    <= 1'b0;
            di_vld_reg    <= 1'b0;
            for (int i = 0; i < DIV_STEPS; i++)
                dv_vld_reg[i] <= 1'b0;
            mu_vld_reg    <= 1'b0;
            dl_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            for (int i = 0; i < SQ_STEPS; i++)
                sq_vld_reg[i] <= (i == 0) ? s3_vld_reg : sq_vld_reg[i-1];
            rr_vld_reg    <= sq_vld_reg[SQ_STEPS-1];
            rp_vld_reg    <= rr_vld_reg;
            r3_vld_reg    <= rp_vld_reg;
            di_vld_reg    <= r3_vld_reg;
            for (int i = 0; i < DIV_STEPS; i++)
                dv_vld_reg[i] <= (i == 0) ? di_vld_reg : dv_vld_reg[i-1];
            mu_vld_reg    <= dv_vld_reg[DIV_STEPS-1];
            dl_vld_reg    <= mu_vld_reg;
            out_valid_reg <= dl_vld_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign new_first_vel_x  = o_v1x_reg;
    assign new_first_vel_y  = o_v1y_reg;
    assign new_second_vel_x = o_v2x_reg;
    assign new_second_vel_y = o_v2y_reg;
    assign coincident       = o_coinc_reg;
    assign saturated        = o_sat_reg;

endmodule
